[hw/rtl/bsp_pkg.sv]
// bsp_pkg: types, codes and helpers shared by the bit stream packer modules
// no dependencies
package bsp_pkg;

  localparam int unsigned DATA_W          = 64;
  localparam int unsigned AMT_W           = 17;
  localparam int unsigned OFF_W           = $clog2(DATA_W);
  localparam int unsigned CH_W            = OFF_W + 1;
  localparam int unsigned DEF_STORE_WORDS = 1024;

  typedef enum logic [2:0] {
    OP_APPEND_FIELD = 3'd0,
    OP_APPEND_RUN   = 3'd1,
    OP_READ_FIELD   = 3'd2,
    OP_RESIZE       = 3'd3,
    OP_CLEAR        = 3'd4
  } bsp_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_PAST_END = 2'd2,
    ST_TOO_LONG = 2'd3
  } bsp_status_t;

  typedef enum logic [1:0] {
    SU_FIELD,
    SU_RUN,
    SU_GROW,
    SU_TRUNC
  } bsp_setup_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] value;
    logic [AMT_W-1:0]  amount;
  } bsp_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [AMT_W-1:0]  length_bits;
    logic [AMT_W-1:0]  read_position;
    logic [1:0]        status;
  } bsp_out_t;

  typedef struct packed {
    logic        load_item;
    logic        setup_en;
    bsp_setup_t  setup;
    logic        clear;
    logic        rd_tail;
    logic        wr_tail;
    logic        rd_b;
    logic        rd_fin;
    logic        load_out;
    bsp_status_t status;
  } bsp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       too_long;
    logic       app_over;
    logic       rsz_over;
    logic       grow;
    logic       tail_off_nz;
    logic       left_zero;
    logic       past_end;
  } bsp_sts_t;

  function automatic logic [DATA_W-1:0] low_mask(input logic [CH_W-1:0] n);
    logic [DATA_W-1:0] m;
    if (n >= CH_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << n[OFF_W-1:0]) - DATA_W'(1);
    end
    return m;
  endfunction

endpackage

[hw/rtl/bit_stream_packer_core.sv]
// bit_stream_packer_core: bit buffer in a 64-bit word memory, packed lsb first
// clear, unknown and rejected ops go from decode straight to the result register; a read
// fetches the two words at the cursor; a shrinking resize rewrites a partial tail word;
// appends and growing resizes fill the tail word by word, reading a partial tail word first
// one item in work at a time, the next beat is taken the cycle after its result is registered
// reset clears length and read cursor only, the word memory is not cleared
module bit_stream_packer_core #(
  parameter int unsigned STORE_WORDS = bsp_pkg::DEF_STORE_WORDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsp_pkg::bsp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bsp_pkg::bsp_out_t out_data
);
  import bsp_pkg::*;

  bsp_cmd_t cmd;
  bsp_sts_t sts;

  bsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsp_dpath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second beat while one was in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OVERFLOW || out_data.status == ST_TOO_LONG)
      |-> out_data.read_data == '0)
    else $error("rejected op returned read data");

  a_write_only_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_tail |-> in_stall && !cmd.load_out)
    else $error("memory write outside an item in work");

endmodule

[hw/rtl/bsp_ram.sv]
// bsp_ram: generic single write port, single read port memory, registered read
// no dependencies beyond bsp_pkg defaults
module bsp_ram #(
  parameter int unsigned WIDTH = bsp_pkg::DATA_W,
  parameter int unsigned DEPTH = bsp_pkg::DEF_STORE_WORDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bsp_dpath.sv]
// bsp_dpath: length, cursor and append/read registers around the word memory
// depends on bsp_pkg and bsp_ram
module bsp_dpath #(
  parameter int unsigned STORE_WORDS = bsp_pkg::DEF_STORE_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bsp_pkg::bsp_in_t   in_data,
  input  bsp_pkg::bsp_cmd_t  cmd,
  output bsp_pkg::bsp_sts_t  sts,
  output bsp_pkg::bsp_out_t  out_data
);
  import bsp_pkg::*;

  localparam int unsigned CAP = STORE_WORDS * DATA_W;
  localparam int unsigned LW  = $clog2(CAP + 1);
  localparam int unsigned SW  = ((LW > AMT_W) ? LW : AMT_W) + 1;
  localparam int unsigned AW  = $clog2(STORE_WORDS);
  localparam int unsigned IW  = LW - OFF_W;
  localparam logic [SW-1:0] CAP_S = SW'(CAP);

  logic [2:0]        op_r;
  logic [DATA_W-1:0] value_r;
  logic [AMT_W-1:0]  amount_r;
  logic [LW-1:0]     len_r;
  logic [LW-1:0]     cur_r;
  logic [AMT_W-1:0]  left_r;
  logic [DATA_W-1:0] src_r;
  logic              fill_r;
  logic [DATA_W-1:0] word_a_r;
  logic [DATA_W-1:0] data_r;
  bsp_out_t          out_r;

  logic [OFF_W-1:0]    off;
  logic [CH_W-1:0]     room;
  logic [CH_W-1:0]     chunk;
  logic [DATA_W-1:0]   base;
  logic [DATA_W-1:0]   wdata;
  logic [2*DATA_W-1:0] src_shift;
  logic [IW-1:0]       cur_word;
  logic [IW:0]         cur_word1;
  logic                valid_a;
  logic                valid_b;
  logic [AW-1:0]       raddr;
  logic [DATA_W-1:0]   rdata;
  logic [OFF_W-1:0]    bi;
  logic [DATA_W-1:0]   word_b;
  logic [DATA_W-1:0]   rd_val;
  logic [LW-1:0]       avail;
  logic [CH_W-1:0]     eff;
  logic [SW-1:0]       amt_s;
  logic [SW-1:0]       len_s;
  logic [SW-1:0]       sum_rd;
  logic [LW-1:0]       cur_rd;

  assign amt_s = SW'(amount_r);
  assign len_s = SW'(len_r);

  // append step at the tail
  assign off       = len_r[OFF_W-1:0];
  assign room      = CH_W'(DATA_W) - {1'b0, off};
  assign chunk     = (left_r < AMT_W'(room)) ? CH_W'(left_r) : room;
  assign base      = (off != '0) ? rdata : '0;
  assign wdata     = (base & low_mask({1'b0, off})) | ((src_r & low_mask(chunk)) << off);
  assign src_shift = {{DATA_W{fill_r}}, src_r} >> chunk;

  // field read at the cursor
  assign cur_word  = cur_r[LW-1:OFF_W];
  assign cur_word1 = {1'b0, cur_word} + (IW+1)'(1);
  assign valid_a   = {cur_word, {OFF_W{1'b0}}} < len_r;
  assign valid_b   = {cur_word1, {OFF_W{1'b0}}} < {1'b0, len_r};
  assign bi        = cur_r[OFF_W-1:0];
  assign word_b    = valid_b ? rdata : '0;
  assign rd_val    = (word_a_r >> bi) |
                     ((bi != '0) ? (word_b << (OFF_W'(0) - bi)) : '0);
  assign avail     = (len_r > cur_r) ? (len_r - cur_r) : '0;
  assign eff       = (SW'(avail) < amt_s) ? CH_W'(avail) : CH_W'(amount_r);
  assign sum_rd    = SW'(cur_r) + amt_s;
  assign cur_rd    = (sum_rd > CAP_S) ? LW'(CAP) : LW'(sum_rd);

  always_comb begin
    if (cmd.rd_tail) begin
      raddr = AW'(len_r[LW-1:OFF_W]);
    end else if (cmd.rd_b) begin
      raddr = AW'(cur_word1);
    end else begin
      raddr = AW'(cur_word);
    end
  end

  bsp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_tail),
    .waddr (AW'(len_r[LW-1:OFF_W])),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cur_r <= '0;
    end else begin
      if (cmd.clear) begin
        len_r <= '0;
        cur_r <= '0;
      end
      if (cmd.setup_en && cmd.setup == SU_TRUNC) begin
        len_r <= LW'(amount_r);
      end
      if (cmd.wr_tail) begin
        len_r <= len_r + LW'(chunk);
      end
      if (cmd.rd_fin) begin
        cur_r <= cur_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r     <= in_data.op;
      value_r  <= in_data.value;
      amount_r <= in_data.amount;
      data_r   <= '0;
    end
    if (cmd.setup_en) begin
      unique case (cmd.setup)
        SU_FIELD: begin
          left_r <= amount_r;
          src_r  <= value_r;
          fill_r <= 1'b0;
        end
        SU_RUN: begin
          left_r <= amount_r;
          src_r  <= {DATA_W{value_r[0]}};
          fill_r <= value_r[0];
        end
        SU_GROW: begin
          left_r <= AMT_W'(amt_s - len_s);
          src_r  <= '0;
          fill_r <= 1'b0;
        end
        SU_TRUNC: begin
          left_r <= '0;
          src_r  <= '0;
          fill_r <= 1'b0;
        end
        default: begin
          left_r <= '0;
        end
      endcase
    end
    if (cmd.wr_tail) begin
      left_r <= left_r - AMT_W'(chunk);
      src_r  <= src_shift[DATA_W-1:0];
    end
    if (cmd.rd_b) begin
      word_a_r <= valid_a ? rdata : '0;
    end
    if (cmd.rd_fin) begin
      data_r <= rd_val & low_mask(eff);
    end
    if (cmd.load_out) begin
      out_r.read_data     <= data_r;
      out_r.length_bits   <= AMT_W'(len_r);
      out_r.read_position <= AMT_W'(cur_r);
      out_r.status        <= cmd.status;
    end
  end

  assign sts.op          = op_r;
  assign sts.too_long    = amount_r > AMT_W'(DATA_W);
  assign sts.app_over    = (len_s + amt_s) > CAP_S;
  assign sts.rsz_over    = amt_s > CAP_S;
  assign sts.grow        = amt_s >= len_s;
  assign sts.tail_off_nz = off != '0;
  assign sts.left_zero   = left_r == '0;
  assign sts.past_end    = sum_rd > len_s;

  assign out_data = out_r;

endmodule

[hw/rtl/bsp_ctrl.sv]
// bsp_ctrl: sequencer for the bit stream packer, issues datapath commands
// depends on bsp_pkg
module bsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bsp_pkg::bsp_sts_t sts,
  output bsp_pkg::bsp_cmd_t cmd
);
  import bsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_APP,
    S_APP_WR,
    S_TRUNC,
    S_TRUNC_WR,
    S_RD_B,
    S_RD_FIN,
    S_FIN
  } state_t;

  state_t      state_r, state_nxt;
  bsp_status_t st_r, st_nxt;
  logic        out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.status = st_r;
    state_nxt  = state_r;
    st_nxt     = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          st_nxt        = ST_OK;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (sts.op)
          OP_APPEND_FIELD: begin
            if (sts.too_long) begin
              st_nxt = ST_TOO_LONG;
            end else if (sts.app_over) begin
              st_nxt = ST_OVERFLOW;
            end else begin
              cmd.setup_en = 1'b1;
              cmd.setup    = SU_FIELD;
              state_nxt    = S_APP;
            end
          end
          OP_APPEND_RUN: begin
            if (sts.app_over) begin
              st_nxt = ST_OVERFLOW;
            end else begin
              cmd.setup_en = 1'b1;
              cmd.setup    = SU_RUN;
              state_nxt    = S_APP;
            end
          end
          OP_READ_FIELD: begin
            if (sts.too_long) begin
              st_nxt = ST_TOO_LONG;
            end else begin
              state_nxt = S_RD_B;
            end
          end
          OP_RESIZE: begin
            if (sts.rsz_over) begin
              st_nxt = ST_OVERFLOW;
            end else if (sts.grow) begin
              cmd.setup_en = 1'b1;
              cmd.setup    = SU_GROW;
              state_nxt    = S_APP;
            end else begin
              cmd.setup_en = 1'b1;
              cmd.setup    = SU_TRUNC;
              state_nxt    = S_TRUNC;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_APP: begin
        if (sts.left_zero) begin
          state_nxt = S_FIN;
        end else if (sts.tail_off_nz) begin
          cmd.rd_tail = 1'b1;
          state_nxt   = S_APP_WR;
        end else begin
          cmd.wr_tail = 1'b1;
        end
      end
      S_APP_WR: begin
        cmd.wr_tail = 1'b1;
        state_nxt   = S_APP;
      end
      S_TRUNC: begin
        if (sts.tail_off_nz) begin
          cmd.rd_tail = 1'b1;
          state_nxt   = S_TRUNC_WR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TRUNC_WR: begin
        cmd.wr_tail = 1'b1;
        state_nxt   = S_FIN;
      end
      S_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_RD_FIN;
      end
      S_RD_FIN: begin
        cmd.rd_fin = 1'b1;
        if (sts.past_end) begin
          st_nxt = ST_PAST_END;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule
